// ===== sv/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, codes and pipeline word types for the strided slice
// resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  // width the resolved index is wrapped at before its low 32 bits are taken
  localparam int INDEX_WIDTH = 32;

  // one divider cell per quotient bit
  localparam int DIV_BITS = 32;

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_STEP   = 2'd1,
    ST_UNBOUNDED   = 2'd2,
    ST_START_UNDEF = 2'd3
  } status_t;

  // fields that ride along the divider chain untouched
  typedef struct packed {
    logic signed [31:0] idx;
    logic               inb;
    status_t            status;
    logic               zero_cnt;
  } ssr_side_t;

  // word handed from cell to cell
  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] dq;
    logic [DIV_BITS-1:0] den;
    ssr_side_t           side;
  } ssr_div_t;

endpackage

`default_nettype wire

// ===== sv/ssr_in_if.sv =====
// ----------------------------------------------------------------------------
// ssr_in_if
// Descriptor channel: valid/ready handshake with the range descriptor word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] range_start;
  logic               start_absent;
  logic signed [31:0] range_stop;
  logic               stop_absent;
  logic signed [31:0] range_step;
  logic               step_absent;
  logic               closed_end;
  logic               have_target;
  logic [30:0]        target_length;
  logic [30:0]        element_number;

  modport source (
    output valid, range_start, start_absent, range_stop, stop_absent,
           range_step, step_absent, closed_end, have_target, target_length,
           element_number,
    input  ready
  );

  modport sink (
    input  valid, range_start, start_absent, range_stop, stop_absent,
           range_step, step_absent, closed_end, have_target, target_length,
           element_number,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ssr_out_if.sv =====
// ----------------------------------------------------------------------------
// ssr_out_if
// Result channel: valid/ready handshake with the resolved range word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_out_if import ssr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [30:0]        element_count;
  logic signed [31:0] resolved_index;
  logic               index_in_bounds;
  status_t            status;

  modport source (
    output valid, element_count, resolved_index, index_in_bounds, status,
    input  ready
  );

  modport sink (
    input  valid, element_count, resolved_index, index_in_bounds, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/strided_slice_resolver.sv =====
// ----------------------------------------------------------------------------
// strided_slice_resolver
// Resolves a strided range descriptor into its element count and the index
// of one chosen element.
// ----------------------------------------------------------------------------
// Accepts one descriptor word per clock unless the result side stalls, and
// returns one result word for each, in order. A word passes two front-end
// stages (bound resolution and the 31x32 multiply, then the index sum and
// the distance), 32 divider cells that each retire one quotient bit of
// distance / |step|, and the output register. Every stage holds its own
// valid bit, so empty stages fill even while a result waits to be taken.
// status: 0 ok, 1 zero step, 2 count unbounded (no target, forward, no stop),
// 3 start indeterminate (no target, reverse, no start); counts saturate at
// 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_slice_resolver import ssr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ssr_in_if.sink    in_ch,
  ssr_out_if.source out_ch
);

  ssr_div_t chain_data  [DIV_BITS+1];
  logic     chain_valid [DIV_BITS+1];
  logic     chain_ready [DIV_BITS+1];

  logic        out_valid_r;
  logic [30:0] count_r, count_nxt;
  ssr_side_t   side_r;
  logic        out_load;
  logic [DIV_BITS-1:0] quo;

  // front end
  ssr_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_data  (chain_data[0]),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    ssr_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_data   (chain_data[i]),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .out_data  (chain_data[i+1]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1])
    );
  end

  // output register: count = quotient + 1, saturated, or zero
  assign chain_ready[DIV_BITS] = !out_valid_r || out_ch.ready;
  assign out_load = chain_ready[DIV_BITS] && chain_valid[DIV_BITS];
  assign quo      = chain_data[DIV_BITS].dq;

  always_comb begin
    if (chain_data[DIV_BITS].side.zero_cnt) begin
      count_nxt = '0;
    end else if (quo[31] || (&quo[30:0])) begin
      count_nxt = COUNT_MAX;
    end else begin
      count_nxt = quo[30:0] + 31'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chain_ready[DIV_BITS]) begin
      out_valid_r <= chain_valid[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count_r <= count_nxt;
      side_r  <= chain_data[DIV_BITS].side;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.element_count   = count_r;
  assign out_ch.resolved_index  = side_r.idx;
  assign out_ch.index_in_bounds = side_r.inb;
  assign out_ch.status          = side_r.status;

  // a zero step or indeterminate start gives a zero count, a zero index and no in-bounds flag
  a_forced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (side_r.status == ST_ZERO_STEP || side_r.status == ST_START_UNDEF)
    |-> count_r == '0 && side_r.idx == 32'sd0 && !side_r.inb)
    else $error("forced-zero result carries nonzero fields");

  // a nonzero count or an in-bounds index only comes with status ok
  a_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (count_r != '0 || side_r.inb) |-> side_r.status == ST_OK)
    else $error("count or bound flag set on a flagged result");

  // the output register holds while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(count_r) && $stable(side_r))
    else $error("result word changed under stall");

endmodule

`default_nettype wire

// ===== sv/ssr_prep.sv =====
// ----------------------------------------------------------------------------
// ssr_prep
// Two-stage front end: resolves bounds, multiplies, forms the index and the
// divider operands for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_prep import ssr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ssr_in_if.sink     in_ch,
  output ssr_div_t   out_data,
  output logic       out_valid,
  input  wire logic  out_ready
);

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] e;
    logic               neg;
    logic               closed;
    logic               tgt;
    logic [30:0]        len;
    logic [31:0]        mag;
    logic signed [62:0] prod;
    status_t            status;
  } s1_t;

  s1_t        s1_r, s1_nxt;
  logic       s1_valid_r;
  ssr_div_t   s2_r, s2_nxt;
  logic       s2_valid_r;
  logic       s1_ready, s2_ready;

  logic signed [31:0] step_c, len_c, s_base, e_base;
  logic               zero_c, neg_c;

  logic signed [31:0] a_c, b_c;
  logic signed [32:0] diff_c;
  logic signed [63:0] sum_c;
  logic signed [INDEX_WIDTH-1:0] idx_w;
  logic signed [63:0] idx_x;
  logic               inb_c, force_c;

  // stage handshake, bubbles collapse
  assign s2_ready    = !s2_valid_r || out_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign out_valid   = s2_valid_r;
  assign out_data    = s2_r;

  // stage 1: defaults, target wrap of negative bounds, product
  always_comb begin
    step_c = in_ch.step_absent ? 32'sd1 : in_ch.range_step;
    zero_c = (step_c == 32'sd0);
    neg_c  = step_c[31];
    len_c  = signed'({1'b0, in_ch.target_length});

    if (in_ch.start_absent) begin
      s_base = neg_c ? len_c - 32'sd1 : 32'sd0;
    end else begin
      s_base = in_ch.range_start;
    end
    if (in_ch.stop_absent) begin
      e_base = neg_c ? (in_ch.closed_end ? 32'sd0 : -32'sd1) : len_c;
    end else begin
      e_base = in_ch.range_stop;
    end

    s1_nxt.s      = (in_ch.have_target && s_base[31]) ? s_base + len_c : s_base;
    s1_nxt.e      = (in_ch.have_target && e_base[31] && !in_ch.stop_absent)
                    ? e_base + len_c : e_base;
    s1_nxt.neg    = neg_c;
    s1_nxt.closed = in_ch.closed_end;
    s1_nxt.tgt    = in_ch.have_target;
    s1_nxt.len    = in_ch.target_length;
    s1_nxt.mag    = neg_c ? 32'(-step_c) : 32'(step_c);
    s1_nxt.prod   = 63'(signed'({1'b0, in_ch.element_number})) * 63'(step_c);

    priority if (zero_c) begin
      s1_nxt.status = ST_ZERO_STEP;
    end else if (neg_c && !in_ch.have_target && in_ch.start_absent) begin
      s1_nxt.status = ST_START_UNDEF;
    end else if (!neg_c && !in_ch.have_target && in_ch.stop_absent) begin
      s1_nxt.status = ST_UNBOUNDED;
    end else begin
      s1_nxt.status = ST_OK;
    end
  end

  // stage 2: distance with open/closed folded into the carry, index sum
  always_comb begin
    a_c    = s1_r.neg ? s1_r.s : s1_r.e;
    b_c    = s1_r.neg ? s1_r.e : s1_r.s;
    diff_c = 33'(a_c) + 33'(~b_c) + 33'(s1_r.closed);

    sum_c  = 64'(s1_r.s) + 64'(s1_r.prod);
    idx_w  = sum_c[INDEX_WIDTH-1:0];
    idx_x  = 64'(idx_w);
    inb_c  = s1_r.tgt && !idx_x[63] && ($unsigned(idx_x) < 64'(s1_r.len));

    force_c = (s1_r.status == ST_ZERO_STEP) || (s1_r.status == ST_START_UNDEF);

    s2_nxt.rem           = '0;
    s2_nxt.dq            = diff_c[31:0];
    s2_nxt.den           = s1_r.mag;
    s2_nxt.side.idx      = force_c ? 32'sd0 : idx_x[31:0];
    s2_nxt.side.inb      = force_c ? 1'b0 : inb_c;
    s2_nxt.side.status   = s1_r.status;
    s2_nxt.side.zero_cnt = diff_c[32] || (s1_r.status != ST_OK);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_ch.valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) s1_r <= s1_nxt;
    if (s2_ready && s1_valid_r)  s2_r <= s2_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/ssr_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssr_div_cell
// One restoring-division cell: takes one dividend bit into the remainder,
// produces one quotient bit and passes the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_div_cell import ssr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ssr_div_t in_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  output ssr_div_t      out_data,
  output logic          out_valid,
  input  wire logic     out_ready
);

  ssr_div_t           word_r, word_nxt;
  logic               valid_r;
  logic [DIV_BITS:0]   shifted;
  logic [DIV_BITS+1:0] trial;
  logic               ge;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = word_r;

  // shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    shifted  = {in_data.rem, in_data.dq[DIV_BITS-1]};
    trial    = {1'b0, shifted} - {2'b00, in_data.den};
    ge       = !trial[DIV_BITS+1];
    word_nxt = in_data;
    word_nxt.rem = ge ? trial[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
    word_nxt.dq  = {in_data.dq[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) word_r <= word_nxt;
  end

endmodule

`default_nettype wire
